// ----- src/besc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package besc_pkg;

    // Fixed field widths of the stream words
    localparam int unsigned IN_FIELD_W = 32;
    localparam int unsigned OUT_W      = 16;

    // Fraction bits of the log2 result, one per squaring stage
    localparam int unsigned LOG_FRAC   = 30;

    // ln 2 in Q0.32
    localparam logic [63:0] LN2_Q32    = 64'd2977044472;

    // Largest entropy code, ln 2 in Q0.16
    localparam logic [OUT_W-1:0] ENT_MAX = 16'd45426;

endpackage
`default_nettype wire

// ----- src/besc_log2.sv -----
`timescale 1ns / 1ps
`default_nettype none
module besc_log2 #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                                          aclk,
    input  wire logic                                          en,
    input  wire logic [FRAC_BITS-1:0]                          q_in,
    output logic [$clog2(FRAC_BITS)+besc_pkg::LOG_FRAC-1:0]   log_out
);
    import besc_pkg::*;

    localparam int unsigned NW = $clog2(FRAC_BITS);

    logic [NW-1:0]       n_in;
    logic [4:0]          shamt;
    logic [31:0]         mant_in;

    logic [31:0]         m_reg    [0:LOG_FRAC];
    logic [NW-1:0]       n_reg    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_reg [0:LOG_FRAC];

    logic [63:0]         sq       [1:LOG_FRAC];
    logic [31:0]         m_next   [1:LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_next[1:LOG_FRAC];

    // Leading-one position and Q1.31 mantissa
    always_comb begin
        n_in = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (q_in[i]) begin
                n_in = NW'(i);
            end
        end
        shamt   = 5'd31 - 5'(n_in);
        mant_in = 32'(q_in) << shamt;
    end

    // One squaring per stage yields one fraction bit
    always_comb begin
        for (int k = 1; k <= LOG_FRAC; k++) begin
            sq[k] = 64'(m_reg[k-1]) * 64'(m_reg[k-1]);
            if (sq[k][63]) begin
                m_next[k]    = sq[k][63:32];
                frac_next[k] = {frac_reg[k-1][LOG_FRAC-2:0], 1'b1};
            end else begin
                m_next[k]    = sq[k][62:31];
                frac_next[k] = {frac_reg[k-1][LOG_FRAC-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= mant_in;
            n_reg[0]    <= n_in;
            frac_reg[0] <= '0;
            for (int k = 1; k <= LOG_FRAC; k++) begin
                m_reg[k]    <= m_next[k];
                n_reg[k]    <= n_reg[k-1];
                frac_reg[k] <= frac_next[k];
            end
        end
    end

    assign log_out = {n_reg[LOG_FRAC], frac_reg[LOG_FRAC]};

endmodule
`default_nettype wire

// ----- src/binary_entropy_separation_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Word bits                                   Accepted when
// s_axis   in   tdata[31:0] signal_weight, [63:32] bkg wt    s_axis_tvalid & s_axis_tready
// m_axis   out  tdata[15:0] entropy_value                    m_axis_tvalid & m_axis_tready
//
// One word per cycle enters while m_axis does not stall; the path runs through
// the divider steps, the log2 squaring chain and the scaling registers.
// aresetn (synchronous, active low) clears every valid bit; data regs hold.
// The whole pipe advances together; a stall on m_axis holds every stage
// and drops s_axis_tready, so nothing is lost or repeated.
module binary_entropy_separation_core #(
    parameter int unsigned WEIGHT_BITS = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [2*besc_pkg::IN_FIELD_W-1:0] s_axis_tdata,  // signal_weight, background_weight
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [besc_pkg::OUT_W-1:0]            m_axis_tdata   // entropy_value
);
    import besc_pkg::*;

    localparam int unsigned UB     = (WEIGHT_BITS < IN_FIELD_W) ? WEIGHT_BITS : IN_FIELD_W;
    localparam int unsigned SUMW   = WEIGHT_BITS + 1;
    localparam int unsigned NW     = $clog2(FRAC_BITS);
    localparam int unsigned LW     = NW + LOG_FRAC;
    localparam int unsigned TW     = $clog2(FRAC_BITS + 1) + LOG_FRAC;
    localparam int unsigned PW     = FRAC_BITS + TW;
    localparam int unsigned LOGLAT = LOG_FRAC + 1;

    logic en;

    // Input sign extension and corner cases
    logic signed [UB-1:0]   s_lo, b_lo;
    logic signed [SUMW-1:0] s_w, b_w, sum_w;
    logic                   zero_in;

    // Divider stages
    logic [SUMW-1:0]      r_reg  [0:FRAC_BITS];
    logic [SUMW-1:0]      d_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] dq_reg [0:FRAC_BITS];
    logic                 dz_reg [0:FRAC_BITS];
    logic                 dv_reg [0:FRAC_BITS];
    logic [SUMW-1:0]      r_sh   [1:FRAC_BITS];

    // Purity and its complement
    logic [FRAC_BITS-1:0] q_reg, qc_reg;
    logic                 qz_reg, qv_reg;

    // Delay line beside the log2 units
    logic [FRAC_BITS-1:0] lq_reg  [0:LOGLAT-1];
    logic [FRAC_BITS-1:0] lqc_reg [0:LOGLAT-1];
    logic                 lz_reg  [0:LOGLAT-1];
    logic                 lv_reg  [0:LOGLAT-1];

    logic [LW-1:0] log_a, log_b;
    logic [TW-1:0] t_a, t_b;
    logic [PW-1:0] p_a, p_b;

    logic [31:0] xa_reg, xb_reg;
    logic        xz_reg, xv_reg;
    logic [63:0] ya_reg, yb_reg;
    logic        yz_reg, yv_reg;
    logic [63:0] acc;
    logic [17:0] rnd;

    logic [OUT_W-1:0] out_reg;
    logic             ov_reg;

    // Advance everything unless a finished word is held
    assign en            = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        s_lo    = s_axis_tdata[UB-1:0];
        b_lo    = s_axis_tdata[IN_FIELD_W +: UB];
        s_w     = SUMW'(s_lo);
        b_w     = SUMW'(b_lo);
        sum_w   = s_w + b_w;
        zero_in = (sum_w <= 0) || (s_w <= 0) || (b_w <= 0);
    end

    // One restoring step per stage
    always_comb begin
        for (int k = 1; k <= FRAC_BITS; k++) begin
            r_sh[k] = {r_reg[k-1][SUMW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]  <= s_w;
            d_reg[0]  <= SUMW'(sum_w[WEIGHT_BITS-1:0]);
            dq_reg[0] <= '0;
            dz_reg[0] <= zero_in;
            for (int k = 1; k <= FRAC_BITS; k++) begin
                d_reg[k]  <= d_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
                if (r_sh[k] >= d_reg[k-1]) begin
                    r_reg[k]  <= r_sh[k] - d_reg[k-1];
                    dq_reg[k] <= {dq_reg[k-1][FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_reg[k]  <= r_sh[k];
                    dq_reg[k] <= {dq_reg[k-1][FRAC_BITS-2:0], 1'b0};
                end
            end

            // Force zero purity on corner cases so both logs stay sane
            q_reg  <= dz_reg[FRAC_BITS] ? '0 : dq_reg[FRAC_BITS];
            qc_reg <= dz_reg[FRAC_BITS] ? '0 : (FRAC_BITS'(0) - dq_reg[FRAC_BITS]);
            qz_reg <= dz_reg[FRAC_BITS] || (dq_reg[FRAC_BITS] == '0);

            lq_reg[0]  <= q_reg;
            lqc_reg[0] <= qc_reg;
            lz_reg[0]  <= qz_reg;
            for (int k = 1; k < LOGLAT; k++) begin
                lq_reg[k]  <= lq_reg[k-1];
                lqc_reg[k] <= lqc_reg[k-1];
                lz_reg[k]  <= lz_reg[k-1];
            end

            xa_reg <= p_a[FRAC_BITS-2 +: 32];
            xb_reg <= p_b[FRAC_BITS-2 +: 32];
            xz_reg <= lz_reg[LOGLAT-1];

            ya_reg <= 64'(xa_reg) * LN2_Q32;
            yb_reg <= 64'(xb_reg) * LN2_Q32;
            yz_reg <= xz_reg;

            out_reg <= yz_reg ? '0 : rnd[16:1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= FRAC_BITS; k++) begin
                dv_reg[k] <= 1'b0;
            end
            qv_reg <= 1'b0;
            for (int k = 0; k < LOGLAT; k++) begin
                lv_reg[k] <= 1'b0;
            end
            xv_reg <= 1'b0;
            yv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= s_axis_tvalid;
            for (int k = 1; k <= FRAC_BITS; k++) begin
                dv_reg[k] <= dv_reg[k-1];
            end
            qv_reg    <= dv_reg[FRAC_BITS];
            lv_reg[0] <= qv_reg;
            for (int k = 1; k < LOGLAT; k++) begin
                lv_reg[k] <= lv_reg[k-1];
            end
            xv_reg <= lv_reg[LOGLAT-1];
            yv_reg <= xv_reg;
            ov_reg <= yv_reg;
        end
    end

    besc_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_p (
        .aclk    (aclk),
        .en      (en),
        .q_in    (q_reg),
        .log_out (log_a)
    );

    besc_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_c (
        .aclk    (aclk),
        .en      (en),
        .q_in    (qc_reg),
        .log_out (log_b)
    );

    // -log2(p) scaled by 2^LOG_FRAC, then p * that
    always_comb begin
        t_a = TW'(FRAC_BITS) * (TW'(1) << LOG_FRAC) - TW'(log_a);
        t_b = TW'(FRAC_BITS) * (TW'(1) << LOG_FRAC) - TW'(log_b);
        p_a = PW'(lq_reg[LOGLAT-1]) * PW'(t_a);
        p_b = PW'(lqc_reg[LOGLAT-1]) * PW'(t_b);
        acc = ya_reg + yb_reg;
        rnd = 18'(acc[63:47]) + 18'd1;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

endmodule
`default_nettype wire

// ----- src/besc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module besc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [63:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    import besc_pkg::*;

    // Reset empties the output
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Input side stalls exactly when a held word blocks the output
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // Held word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // Entropy never exceeds ln 2
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata <= ENT_MAX)
        else $error("entropy out of range");

endmodule

bind binary_entropy_separation_core besc_checker u_besc_checker (.*);
`default_nettype wire

// ----- tb/binary_entropy_separation_core_chk.sv -----
`timescale 1ns / 1ps
module binary_entropy_separation_core_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    output int          err_count,
    output int          pending,
    output int          words_out
);
    import besc_pkg::*;

    logic [15:0] entropy_q[$];

    // log2 of q >= 1, 30 fraction bits, by normalize and square
    function automatic logic [63:0] log2_q30(input logic [63:0] q);
        int n;
        logic [63:0] m;
        logic [63:0] frac;
        n = 0;
        frac = 0;
        while (n < 63 && (q >> (n + 1)) != 0) n++;
        m = q << (31 - n);
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(n) << LOG_FRAC) + frac;
    endfunction

    // q/2^16 * -ln(q/2^16) in Q0.64
    function automatic logic [63:0] plogp(input logic [63:0] q);
        logic [63:0] t;
        logic [63:0] x;
        t = (64'd16 << LOG_FRAC) - log2_q30(q);
        x = (q * t) >> (16 + LOG_FRAC - 32);
        return x * LN2_Q32;
    endfunction

    function automatic logic [15:0] entropy_of(input logic [63:0] w);
        logic signed [63:0] s;
        logic signed [63:0] b;
        logic signed [63:0] sum;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] acc;
        s = {{32{w[31]}}, w[31:0]};
        b = {{32{w[63]}}, w[63:32]};
        sum = s + b;
        q = 0;
        if (sum <= 0 || s <= 0 || b <= 0) return 16'd0;
        r = s;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= 64'(sum)) begin
                r = r - 64'(sum);
                q[0] = 1'b1;
            end
        end
        if (q == 0) return 16'd0;
        acc = plogp(q) + plogp(64'h1_0000 - q);
        return 16'(((acc >> 47) + 64'd1) >> 1);
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %0s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    initial begin
        err_count = 0;
        words_out = 0;
    end

    assign pending = entropy_q.size();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) entropy_q.push_back(entropy_of(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                words_out++;
                if (entropy_q.size() == 0) report("unexpected word", m_axis_tdata, 16'd0);
                else begin
                    if (m_axis_tdata !== entropy_q[0])
                        report("entropy_value", m_axis_tdata, entropy_q[0]);
                    void'(entropy_q.pop_front());
                end
            end
        end
    end
endmodule

// ----- tb/binary_entropy_separation_core_tb.sv -----
`timescale 1ns / 1ps
module binary_entropy_separation_core_tb;
    localparam int LATENCY = 16 + 30 + 6;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // [31:0] signal_weight, [63:32] background_weight
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [15:0] entropy_value
    int          err_count;
    int          pending;
    int          words_out;
    int          cycles = 0;
    int          words_in = 0;
    bit          stall_on = 1'b1;

    always #6 aclk = ~aclk;

    binary_entropy_separation_core dut (.*);

    binary_entropy_separation_core_chk chk (.*);

    // Abort a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("binary_entropy_separation_core_tb: done, errors");
            $finish;
        end
    end

    // Receiver stall: alternate free-running stretches with random backpressure
    always @(negedge aclk) begin
        if (cycles % 512 == 0) stall_on <= ($urandom_range(0, 2) != 0);
        m_axis_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // Drive one word and hold it until accepted
    task automatic send_word(input logic [31:0] sig, input logic [31:0] bkg);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bkg, sig};
        do @(posedge aclk); while (!s_axis_tready);
        words_in++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Random weight: mostly positive of assorted magnitude, some negatives and zeros
    function automatic logic [31:0] rand_weight();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 32'($urandom);
            1: return 32'd0;
            2: return 32'($urandom_range(1, 16));
            3: return -32'($urandom_range(1, 1000));
            default: return 32'($urandom) >> $urandom_range(1, 31);
        endcase
    endfunction

    initial begin
        int burst;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, zeros, opposite signs, tiny purity, overflowing sum
        send_word(32'd0, 32'd0);
        send_word(32'd1, 32'd1);
        send_word(32'd5, 32'd0);
        send_word(32'd0, 32'd5);
        send_word(32'h7fff_ffff, 32'h7fff_ffff);
        send_word(32'h8000_0000, 32'h8000_0000);
        send_word(32'h7fff_ffff, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7fff_ffff);
        send_word(32'hffff_ffff, 32'd3);
        send_word(32'd3, 32'hffff_ffff);
        send_word(32'd1, 32'h7fff_ffff);
        send_word(32'h7fff_ffff, 32'd1);
        send_word(32'd1, 32'd65535);
        send_word(32'd1, 32'd65536);
        send_word(32'd1, 32'd3);
        send_word(32'd1, 32'd2);
        send_word(32'hffff_ffff, 32'hffff_ffff);
        send_word(32'h5555_5555, 32'h2aaa_aaaa);
        drop_valid();

        // Hold off until the pipe has drained completely
        wait (pending == 0);

        // Random bursts with gaps
        while (words_in < 2020) begin
            burst = $urandom_range(1, 40);
            repeat (burst) send_word(rand_weight(), rand_weight());
            if ($urandom_range(0, 3) != 0) begin
                drop_valid();
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        drop_valid();

        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge aclk);

        $display("covered %0d words in, %0d entropy words checked, directed edge cases plus random",
                 words_in, words_out);
        if (err_count == 0) $display("binary_entropy_separation_core_tb: done, clean");
        else $display("binary_entropy_separation_core_tb: done, errors");
        $finish;
    end
endmodule
